@@ rtl/des_pkg.sv @@
// Shared types, permutation tables, S-boxes and round functions of the DES core.
`default_nettype none

package des_pkg;

  localparam int NumRounds = 16;

  // One pipeline stage: direction and the two Feistel halves.
  typedef struct packed {
    logic        func;
    logic [31:0] l;
    logic [31:0] r;
  } stage_t;

  typedef logic [NumRounds-1:0][47:0] rkeys_t;

  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
    7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Total left rotation of C and D after each round (running sum of the shifts).
  localparam logic [4:0] ROT_CUM [NumRounds] = '{
    5'd1, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
  };

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
  };

  // Bit 1 in the tables is the most significant bit of the source word.
  function automatic logic [63:0] ip_perm(input logic [63:0] v);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) begin
      res[63-i] = v[6'(7'd64 - IP_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] v);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) begin
      res[63-i] = v[6'(7'd64 - FP_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [47:0] e_perm(input logic [31:0] v);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) begin
      res[47-i] = v[5'(6'd32 - E_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [31:0] p_perm(input logic [31:0] v);
    logic [31:0] res;
    for (int i = 0; i < 32; i++) begin
      res[31-i] = v[5'(6'd32 - P_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [55:0] pc1_perm(input logic [63:0] v);
    logic [55:0] res;
    for (int i = 0; i < 56; i++) begin
      res[55-i] = v[6'(7'd64 - PC1_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [47:0] pc2_perm(input logic [55:0] v);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) begin
      res[47-i] = v[6'(6'd56 - PC2_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] x, input logic [4:0] s);
    return (x << s) | (x >> (5'd28 - s));
  endfunction

  // The round function f(R, K): expansion, key mix, S-boxes, P.
  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] o;
    logic [5:0]  b;
    x = e_perm(r) ^ k;
    for (int j = 0; j < 8; j++) begin
      b = x[47-6*j -: 6];
      o[31-4*j -: 4] = SBOX[j][{b[5], b[0], b[4:1]}];
    end
    return p_perm(o);
  endfunction

endpackage

`default_nettype wire

@@ rtl/des_ifs.sv @@
// Valid/ready channel interfaces for the block input and the result output.
`default_nettype none

interface des_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] block_in;

  modport source (output valid, output func, output block_in, input ready);
  modport sink (input valid, input func, input block_in, output ready);
endinterface

interface des_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out;

  modport source (output valid, output block_out, input ready);
  modport sink (input valid, input block_out, output ready);
endinterface

`default_nettype wire

@@ rtl/des_block_cipher_core.sv @@
// Top level of the single-DES ECB engine: key schedule and sixteen round stages.
`default_nettype none

// Single-DES ECB engine. Write the 64-bit key through cfg_we/cfg_wdata while no
// item is in flight; it is used from the next accepted item on, and parity bits are
// ignored. Each item carries one block and a direction (func 0 encrypts, 1 decrypts).
// The core is a sixteen-stage pipeline, one Feistel round per stage, so it accepts
// one item every cycle unless a stalled output has filled it. A result is valid once
// its item has passed the register of every stage.
// A stall at the output backs up stage by stage; empty stages still fill, so the
// input keeps taking items until all sixteen stages hold one. After reset the key is
// zero and no clearing pass is needed.
module des_block_cipher_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  des_in_if.sink     in_if,
  des_out_if.source  out_if,
  input  wire logic  cfg_we,
  input  wire logic [63:0] cfg_wdata
);

  localparam int N = des_pkg::NumRounds;

  des_pkg::rkeys_t round_keys;
  des_pkg::stage_t stg_in;
  des_pkg::stage_t up_stg  [N];
  des_pkg::stage_t dn_stg  [N];
  logic [N-1:0]    up_vld;
  logic [N-1:0]    dn_vld;
  logic [N:0]      rdy;
  logic [63:0]     ip_out;

  des_key_sched u_key_sched (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .round_keys (round_keys)
  );

  assign ip_out      = des_pkg::ip_perm(in_if.block_in);
  assign stg_in.func = in_if.func;
  assign stg_in.l    = ip_out[63:32];
  assign stg_in.r    = ip_out[31:0];

  assign rdy[N]      = out_if.ready;
  assign in_if.ready = rdy[0];

  for (genvar i = 0; i < N; i++) begin : g_round
    if (i == 0) begin : g_first
      assign up_vld[i] = in_if.valid;
      assign up_stg[i] = stg_in;
    end else begin : g_next
      assign up_vld[i] = dn_vld[i-1];
      assign up_stg[i] = dn_stg[i-1];
    end

    // Decryption walks the schedule backwards.
    des_round u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (up_vld[i]),
      .up_ready (rdy[i]),
      .up_data  (up_stg[i]),
      .key_enc  (round_keys[i]),
      .key_dec  (round_keys[N-1-i]),
      .dn_valid (dn_vld[i]),
      .dn_ready (rdy[i+1]),
      .dn_data  (dn_stg[i])
    );
  end

  // The halves are swapped once more before the final permutation.
  assign out_if.valid     = dn_vld[N-1];
  assign out_if.block_out = des_pkg::fp_perm({dn_stg[N-1].r, dn_stg[N-1].l});

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> dn_vld[0])
    else $error("accepted item did not enter the first stage");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    dn_vld[N-1] && out_if.ready && !dn_vld[N-2] |=> !out_if.valid)
    else $error("result delivered twice from the last stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    dn_vld[N-1] && !out_if.ready |=> dn_vld[N-1] && $stable(dn_stg[N-1]))
    else $error("last stage changed while stalled");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&dn_vld) && !out_if.ready |-> !in_if.ready)
    else $error("input accepted with the pipeline full and stalled");

endmodule

`default_nettype wire

@@ rtl/des_key_sched.sv @@
// Key register and the sixteen round keys derived from it.
`default_nettype none

module des_key_sched (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [63:0]    cfg_wdata,
  output des_pkg::rkeys_t     round_keys
);

  logic [63:0] key_r;
  logic [55:0] cd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r <= cfg_wdata;
    end
  end

  // PC-1, rotations and PC-2 are pure wiring, so the schedule follows the key at once.
  always_comb begin
    cd = des_pkg::pc1_perm(key_r);
    for (int i = 0; i < des_pkg::NumRounds; i++) begin
      round_keys[i] = des_pkg::pc2_perm({des_pkg::rotl28(cd[55:28], des_pkg::ROT_CUM[i]),
                                         des_pkg::rotl28(cd[27:0], des_pkg::ROT_CUM[i])});
    end
  end

endmodule

`default_nettype wire

@@ rtl/des_round.sv @@
// One Feistel round followed by its pipeline register with valid and stall.
`default_nettype none

module des_round (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire des_pkg::stage_t up_data,
  input  wire logic [47:0]     key_enc,
  input  wire logic [47:0]     key_dec,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output des_pkg::stage_t      dn_data
);

  logic            vld_r;
  des_pkg::stage_t data_r;
  des_pkg::stage_t data_nxt;
  logic [47:0]     key;

  assign key      = up_data.func ? key_dec : key_enc;
  assign up_ready = !vld_r || dn_ready;

  always_comb begin
    data_nxt.func = up_data.func;
    data_nxt.l    = up_data.r;
    data_nxt.r    = up_data.l ^ des_pkg::feistel(up_data.r, key);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire
